### hdl/spq_pkg.sv
// ---------------------------------------------------------------------------
// Sorted priority queue package
// Shared sizes, status codes and entry types for the sorted queue chain.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

  // Queue capacity and derived widths
  localparam int DEPTH      = 64;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int DATA_W     = 32;
  localparam int PRIO_W     = 16;
  localparam int OUT_CNT_W  = 7;
  localparam int STATUS_W   = 2;

  // Stream packing
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  // Mode codes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // One stored entry
  typedef struct packed {
    logic [PRIO_W-1:0]        prio;
    logic signed [DATA_W-1:0] data;
  } entry_t;

  // Broadcast control to every cell
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic [PRIO_W-1:0]        prio;
    logic signed [DATA_W-1:0] data;
  } cell_ctl_t;

endpackage

### hdl/spq_cell.sv
// ---------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry; on insert it keeps, takes the new item or takes its left
// neighbour; on remove it takes its right neighbour.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occ,      // slot lies below the fill count
  input  entry_t    left_e,
  input  logic      left_ge,  // left neighbour stays ahead of the new item
  input  entry_t    right_e,
  output entry_t    ent,
  output logic      ge        // this entry stays ahead of the new item
);

  entry_t ent_r;
  entry_t ent_nxt;
  entry_t new_e;

  assign new_e = '{prio: ctl.prio, data: ctl.data};

  // Entries of equal or higher priority stay in place
  assign ge = occ && (ent_r.prio >= ctl.prio);

  // Next entry
  always_comb begin
    ent_nxt = ent_r;
    if (ctl.ins && !ge) begin
      ent_nxt = left_ge ? new_e : left_e;
    end else if (ctl.rem) begin
      ent_nxt = right_e;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

### hdl/sorted_priority_queue_unit.sv
// ---------------------------------------------------------------------------
// Sorted priority queue unit
// Fixed-capacity priority queue kept sorted, highest priority first.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_*: in_tuser is the mode (0 insert, 1 remove), in_tdata
//   carries the data word and priority. Each item gives exactly one result
//   item on out_*: out_tuser is the status, out_tdata the removed entry (zero
//   unless a remove succeeded) and the entry count after the item.
//   Storage is a row of DEPTH cells; an insert shifts every lower-priority
//   entry one cell back and drops the new one into the gap, a remove shifts
//   the whole row one cell forward.
//   The result is registered and valid in the cycle after the item is accepted.
//   Throughput: one item per cycle while the receiver keeps taking results;
//   the single output register is refilled in the cycle it is emptied.
//   Stall: while a result waits with out_tready low, in_tready is low.
//   Reset: the fill count and output valid clear; cell contents are left
//   as they are and are never read before being written.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_priority_queue_unit import spq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // input items
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] item_data, [47:32] item_priority
  input  logic                   in_tuser,   // [0] mode
  // result items
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [31:0] head_data, [47:32] head_priority,
                                             // [54:48] count, [55] zero
  output logic [STATUS_W-1:0]    out_tuser   // [1:0] status
);

  logic                    accept;
  logic                    full;
  logic                    empty;
  cell_ctl_t               ctl;
  entry_t                  ent [DEPTH];
  logic                    ge  [DEPTH];

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]     status_r, status_nxt;
  logic signed [DATA_W-1:0] head_data_r, head_data_nxt;
  logic [PRIO_W-1:0]       head_prio_r, head_prio_nxt;
  logic [OUT_CNT_W-1:0]    out_cnt_r, out_cnt_nxt;

  // Handshake
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);

  // Broadcast control
  assign ctl.ins  = accept && (in_tuser == MODE_INSERT) && !full;
  assign ctl.rem  = accept && (in_tuser == MODE_REMOVE) && !empty;
  assign ctl.data = in_tdata[DATA_W-1:0];
  assign ctl.prio = in_tdata[DATA_W +: PRIO_W];

  // Cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_e;
    logic   left_ge;
    entry_t right_e;

    if (i == 0) begin : g_first
      assign left_e  = '{prio: ctl.prio, data: ctl.data};
      assign left_ge = 1'b1;
    end else begin : g_mid
      assign left_e  = ent[i-1];
      assign left_ge = ge[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_e = ent[i];
    end else begin : g_notlast
      assign right_e = ent[i+1];
    end

    spq_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .occ     (CNT_W'(i) < count_r),
      .left_e  (left_e),
      .left_ge (left_ge),
      .right_e (right_e),
      .ent     (ent[i]),
      .ge      (ge[i])
    );
  end

  // Count and result
  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    head_data_nxt = head_data_r;
    head_prio_nxt = head_prio_r;
    out_cnt_nxt   = out_cnt_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      head_data_nxt = '0;
      head_prio_nxt = '0;
      status_nxt    = ST_DONE;
      if (ctl.ins) begin
        count_nxt = count_r + CNT_W'(1);
      end else if (ctl.rem) begin
        count_nxt     = count_r - CNT_W'(1);
        head_data_nxt = ent[0].data;
        head_prio_nxt = ent[0].prio;
      end else if (in_tuser == MODE_INSERT) begin
        status_nxt = ST_FULL;
      end else begin
        status_nxt = ST_EMPTY;
      end
      out_cnt_nxt = OUT_CNT_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    status_r    <= status_nxt;
    head_data_r <= head_data_nxt;
    head_prio_r <= head_prio_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  // Output packing
  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {1'b0, out_cnt_r, head_prio_r, head_data_r};

endmodule

### hdl/spq_checker.sv
// ---------------------------------------------------------------------------
// Sorted priority queue checker
// Port-level assertions on the queue's result stream, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_checker import spq_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [STATUS_W-1:0]    out_tuser
);

  // A stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result item changed");

  // Every accepted item gives a result in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("no result after accepted item");

  // An empty remove reports no entry and a zero count
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_EMPTY |->
      out_tdata[DATA_W+PRIO_W-1:0] == '0 && out_tdata[54:48] == '0)
    else $error("empty status with data or nonzero count");

  // A rejected insert means the queue is at capacity
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_FULL |->
      out_tdata[54:48] == OUT_CNT_W'(DEPTH) && out_tdata[DATA_W+PRIO_W-1:0] == '0)
    else $error("full status below capacity");

  // Unused status code never appears
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == ST_DONE || out_tuser == ST_FULL || out_tuser == ST_EMPTY)
    else $error("illegal status code");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
